FILE: rtl/rpq_pkg.sv
`default_nettype none
package rpq_pkg;

   localparam int CAPACITY_DEFAULT = 64;

   localparam int NAME_W  = 64;
   localparam int ROLL_W  = 16;
   localparam int SCORE_W = 10;
   localparam int KEY_W   = SCORE_W + ROLL_W;
   localparam int ACT_W   = 2;
   localparam int DATA_W  = 96;

   localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACT_W-1:0] ACT_PEEK   = 2'd1;
   localparam logic [ACT_W-1:0] ACT_POP    = 2'd2;

   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  key;
      logic [NAME_W-1:0] name;
   } entry_type;

   typedef struct packed {
      logic              ins_en;
      logic              pop_en;
      logic [KEY_W-1:0]  key;
      logic [NAME_W-1:0] name;
   } cell_cmd_type;

   // key = {score, ~roll}: larger key means higher priority
   function automatic logic [KEY_W-1:0] make_key(input logic [SCORE_W-1:0] score,
                                                 input logic [ROLL_W-1:0] roll);
      make_key = {score, ~roll};
   endfunction

endpackage
`default_nettype wire

FILE: rtl/rpq_cell.sv
`default_nettype none
module rpq_cell (
   input  wire                  clock,
   input  wire                  reset,
   input  rpq_pkg::cell_cmd_type cmd,
   input  rpq_pkg::entry_type   left_entry,
   input  wire                  left_ge,
   input  rpq_pkg::entry_type   right_entry,
   output rpq_pkg::entry_type   entry,
   output logic                 ge
);

   logic                       valid_ff, valid_in;
   logic [rpq_pkg::KEY_W-1:0]  key_ff, key_in;
   logic [rpq_pkg::NAME_W-1:0] name_ff, name_in;

   // entries at or above the new key stay put; ties keep the older record on top
   assign ge = valid_ff && (key_ff >= cmd.key);

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      name_in  = name_ff;
      if (cmd.ins_en && !ge) begin
         if (left_ge) begin
            valid_in = 1'b1;
            key_in   = cmd.key;
            name_in  = cmd.name;
         end else begin
            valid_in = left_entry.valid;
            key_in   = left_entry.key;
            name_in  = left_entry.name;
         end
      end else if (cmd.pop_en) begin
         valid_in = right_entry.valid;
         key_in   = right_entry.key;
         name_in  = right_entry.name;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      name_ff <= name_in;
   end

   assign entry = '{valid: valid_ff, key: key_ff, name: name_ff};

endmodule
`default_nettype wire

FILE: rtl/record_priority_queue_core.sv
// Handshake: an accepted request sets the pending flag and updates the cell
// row on the accept edge; the output register then captures cell 0 once the
// response channel is free (no response held, or rsp_tready high). req_tready
// is low while a request is pending, so a new request waits until then.
// Reset: synchronous, active high; empties the queue (cell valid bits) and
// clears the pending and response-valid flags.
`default_nettype none
module record_priority_queue_core #(
   parameter int CAPACITY = rpq_pkg::CAPACITY_DEFAULT
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_tvalid,
   output logic                        req_tready,
   input  wire  [rpq_pkg::DATA_W-1:0]  req_tdata,  // name_tag, roll_number, score
   input  wire  [rpq_pkg::ACT_W-1:0]   req_tuser,  // action
   output logic                        rsp_tvalid,
   input  wire                         rsp_tready,
   output logic [rpq_pkg::DATA_W-1:0]  rsp_tdata,  // top_name, top_roll, top_score
   output logic [1:0]                  rsp_tuser   // is_empty, full_drop
);

   localparam int NW = rpq_pkg::NAME_W;
   localparam int RW = rpq_pkg::ROLL_W;
   localparam int SW = rpq_pkg::SCORE_W;

   rpq_pkg::entry_type    cells [CAPACITY];
   logic                  ges   [CAPACITY];
   rpq_pkg::cell_cmd_type cmd;

   logic req_fire, full, is_ins, is_pop, is_peek, load;
   logic pend_ff, pend_in, drop_ff, drop_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [rpq_pkg::DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0] rsp_user_ff, rsp_user_in;

   assign req_tready = !pend_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign full       = cells[CAPACITY-1].valid;
   assign is_ins     = (req_tuser == rpq_pkg::ACT_INSERT);
   assign is_peek    = (req_tuser == rpq_pkg::ACT_PEEK);
   assign is_pop     = (req_tuser == rpq_pkg::ACT_POP);

   always_comb begin
      cmd.ins_en = req_fire && is_ins && !full;
      cmd.pop_en = req_fire && is_pop;
      cmd.name   = req_tdata[NW-1:0];
      cmd.key    = rpq_pkg::make_key(req_tdata[NW+RW +: SW], req_tdata[NW +: RW]);
   end

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         rpq_pkg::entry_type left_e, right_e;
         logic               left_g;
         if (g == 0) begin : g_head
            assign left_e = '0;
            assign left_g = 1'b1;
         end else begin : g_mid
            assign left_e = cells[g-1];
            assign left_g = ges[g-1];
         end
         if (g == CAPACITY - 1) begin : g_tail
            assign right_e = '0;
         end else begin : g_body
            assign right_e = cells[g+1];
         end
         rpq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .cmd         (cmd),
            .left_entry  (left_e),
            .left_ge     (left_g),
            .right_entry (right_e),
            .entry       (cells[g]),
            .ge          (ges[g])
         );
      end
   endgenerate

   assign load = pend_ff && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      pend_in      = pend_ff;
      drop_in      = drop_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         pend_in      = 1'b0;
         rsp_valid_in = 1'b1;
         if (cells[0].valid) begin
            rsp_data_in = {{(rpq_pkg::DATA_W-NW-RW-SW){1'b0}},
                           cells[0].key[RW +: SW], ~cells[0].key[RW-1:0], cells[0].name};
            rsp_user_in = {drop_ff, 1'b0};
         end else begin
            rsp_data_in = '0;
            rsp_user_in = {drop_ff, 1'b1};
         end
      end
      if (req_fire && (is_ins || is_peek || is_pop)) begin
         pend_in = 1'b1;
         drop_in = is_ins && full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      drop_ff     <= drop_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
`default_nettype wire
